[hdl/ghnf_pkg.sv]
// ----------------------------------------------------------------------------
// ghnf_pkg
// Shared types and constants for the grid hole neighbour fill block.
// ----------------------------------------------------------------------------
package ghnf_pkg;

  localparam int MAX_SIDE    = 32;
  localparam int CELLS       = MAX_SIDE * MAX_SIDE;
  localparam int IDX_W       = $clog2(CELLS);
  localparam int COORD_W     = 5;
  localparam int SIDE_W      = 6;
  localparam int HEIGHT_BITS = 24;
  localparam int MARK_W      = 2;
  localparam int NUM_PROBES  = 8;
  localparam int PROBE_CNT_W = $clog2(NUM_PROBES) + 1;

  localparam logic [MARK_W-1:0] MARK_UNDEF  = 2'd0;
  localparam logic [MARK_W-1:0] MARK_MOSAIC = 2'd1;
  localparam logic [MARK_W-1:0] MARK_OTHER  = 2'd2;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // input transaction
  typedef struct packed {
    logic                          func;
    logic [COORD_W-1:0]            row;
    logic [COORD_W-1:0]            col;
    logic signed [HEIGHT_BITS-1:0] height;
    logic [MARK_W-1:0]             mark;
  } item_t;

  // output transaction
  typedef struct packed {
    logic signed [HEIGHT_BITS-1:0] height_res;
    logic [MARK_W-1:0]             mark_res;
    logic                          from_neighbour;
  } result_t;

  // one grid vertex as stored
  typedef struct packed {
    logic signed [HEIGHT_BITS-1:0] height;
    logic [MARK_W-1:0]             mark;
  } vertex_t;

endpackage

[hdl/ghnf_store.sv]
// ----------------------------------------------------------------------------
// ghnf_store
// Single-port vertex memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module ghnf_store (
  input  logic                     clk,
  input  logic                     we,
  input  logic [ghnf_pkg::IDX_W-1:0] addr,
  input  ghnf_pkg::vertex_t        wdata,
  output ghnf_pkg::vertex_t        rdata
);
  import ghnf_pkg::*;

  vertex_t mem [CELLS];

  // write or read one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

[hdl/grid_hole_neighbour_fill_core.sv]
// ----------------------------------------------------------------------------
// grid_hole_neighbour_fill_core
// Square height grid with neighbour fill of undefined vertices on read.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item): a write transaction stores
//   height and mark of one vertex; a read transaction returns one result on
//   the res channel (res_valid / res_stall / res). Positions outside the
//   current grid are dropped without a result.
//   cfg_we / cfg_data set the grid side; write it only while the block is idle.
// Timing:
//   a write is stored when it is accepted. A read of a defined vertex reads
//   the memory at acceptance; its result is loaded into the output register
//   from the registered read data. An undefined vertex probes up to eight
//   neighbours, one memory read per cycle through the single memory port,
//   until one of them has a mosaic mark or all eight are done.
//   Only one transaction is in flight; item_stall is high while a read runs.
// Reset:
//   clears control state and sets the grid side to 32; the vertex memory is
//   not cleared and each vertex must be written before it is read.
// Output stall:
//   the result waits in the output register while res_stall is high; a
//   further read finishing meanwhile holds in a pending register and the
//   block stalls its input until the output register frees.
// ----------------------------------------------------------------------------
module grid_hole_neighbour_fill_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  ghnf_pkg::item_t             item,
  output logic                        res_valid,
  input  logic                        res_stall,
  output ghnf_pkg::result_t           res,
  input  logic                        cfg_we,
  input  logic [ghnf_pkg::SIDE_W-1:0] cfg_data
);
  import ghnf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CENTER = 4'b0010,
    S_PROBE  = 4'b0100,
    S_WAIT   = 4'b1000
  } state_t;

  state_t                  state;
  logic [SIDE_W-1:0]       grid_side;
  logic [SIDE_W-1:0]       side;
  logic [COORD_W-1:0]      row_q;
  logic [COORD_W-1:0]      col_q;
  logic [IDX_W-1:0]        idx_q;
  logic [PROBE_CNT_W-1:0]  probe_cnt;
  logic                    prev_ok;
  vertex_t                 ctr;
  result_t                 pend;

  logic                    accept;
  logic                    in_grid;
  logic [IDX_W-1:0]        in_idx;
  logic [IDX_W-1:0]        probe_addr;
  logic                    probe_ok;
  logic                    col_lo_ok;
  logic                    col_hi_ok;
  logic                    row_lo_ok;
  logic                    row_hi_ok;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_addr;
  vertex_t                 mem_wdata;
  vertex_t                 mem_rdata;
  logic                    out_free;
  logic                    finish;
  logic                    res_load;
  result_t                 fin;
  logic                    hit;

  // grid side register and clamp
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side <= SIDE_W'(MAX_SIDE);
    end else if (cfg_we) begin
      grid_side <= cfg_data;
    end
  end

  always_comb begin
    if (grid_side < SIDE_W'(2)) begin
      side = SIDE_W'(2);
    end else if (grid_side > SIDE_W'(MAX_SIDE)) begin
      side = SIDE_W'(MAX_SIDE);
    end else begin
      side = grid_side;
    end
  end

  // input position check and linear index
  assign in_grid    = ({1'b0, item.row} < side) && ({1'b0, item.col} < side);
  assign in_idx     = IDX_W'(item.row) * IDX_W'(side) + IDX_W'(item.col);
  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && (state == S_IDLE);

  // neighbour probe address and validity
  assign col_lo_ok = (col_q != '0);
  assign col_hi_ok = ({1'b0, col_q} + SIDE_W'(1)) < side;
  assign row_lo_ok = (row_q != '0);
  assign row_hi_ok = ({1'b0, row_q} + SIDE_W'(1)) < side;

  always_comb begin
    unique case (probe_cnt[PROBE_CNT_W-2:0])
      3'd0: begin   // left
        probe_addr = idx_q - IDX_W'(1);
        probe_ok   = col_lo_ok;
      end
      3'd1: begin   // lower-left
        probe_addr = idx_q - IDX_W'(side) - IDX_W'(1);
        probe_ok   = col_lo_ok && row_lo_ok;
      end
      3'd2: begin   // upper-left
        probe_addr = idx_q + IDX_W'(side) - IDX_W'(1);
        probe_ok   = col_lo_ok && row_hi_ok;
      end
      3'd3: begin   // right
        probe_addr = idx_q + IDX_W'(1);
        probe_ok   = col_hi_ok;
      end
      3'd4: begin   // lower-right
        probe_addr = idx_q - IDX_W'(side) + IDX_W'(1);
        probe_ok   = col_hi_ok && row_lo_ok;
      end
      3'd5: begin   // upper-right
        probe_addr = idx_q + IDX_W'(side) + IDX_W'(1);
        probe_ok   = col_hi_ok && row_hi_ok;
      end
      3'd6: begin   // below
        probe_addr = idx_q - IDX_W'(side);
        probe_ok   = row_lo_ok;
      end
      default: begin   // above
        probe_addr = idx_q + IDX_W'(side);
        probe_ok   = row_hi_ok;
      end
    endcase
  end

  // memory port: input address when idle, probe address otherwise
  assign mem_we          = accept && in_grid && (item.func == FUNC_WRITE);
  assign mem_addr        = (state == S_IDLE) ? in_idx : probe_addr;
  assign mem_wdata.height = item.height;
  assign mem_wdata.mark   = (item.mark == MARK_UNDEF || item.mark == MARK_MOSAIC) ?
                            item.mark : MARK_OTHER;

  ghnf_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // result selection when a read completes
  assign hit      = prev_ok && (mem_rdata.mark == MARK_MOSAIC);
  assign out_free = !res_valid || !res_stall;
  assign res_load = out_free && (finish || (state == S_WAIT));

  always_comb begin
    finish = 1'b0;
    fin    = '0;
    if (state == S_CENTER) begin
      fin.height_res     = mem_rdata.height;
      fin.mark_res       = mem_rdata.mark;
      fin.from_neighbour = 1'b0;
      finish             = (mem_rdata.mark != MARK_UNDEF);
    end else if (state == S_PROBE) begin
      fin.mark_res = ctr.mark;
      if (hit) begin
        fin.height_res     = mem_rdata.height;
        fin.from_neighbour = 1'b1;
        finish             = 1'b1;
      end else begin
        fin.height_res     = ctr.height;
        fin.from_neighbour = 1'b0;
        finish             = (probe_cnt == PROBE_CNT_W'(NUM_PROBES));
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      probe_cnt <= '0;
      prev_ok   <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (out_free) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && in_grid && (item.func == FUNC_READ)) begin
            state     <= S_CENTER;
            probe_cnt <= '0;
          end
        end
        S_CENTER, S_PROBE: begin
          if (finish) begin
            if (out_free) begin
              state <= S_IDLE;
            end else begin
              state <= S_WAIT;
            end
          end else begin
            state     <= S_PROBE;
            prev_ok   <= probe_ok;
            probe_cnt <= probe_cnt + PROBE_CNT_W'(1);
          end
        end
        S_WAIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      row_q <= item.row;
      col_q <= item.col;
      idx_q <= in_idx;
    end
    if (state == S_CENTER) begin
      ctr <= mem_rdata;
    end
    if (finish) begin
      pend <= fin;
      if (out_free) begin
        res <= fin;
      end
    end else if (state == S_WAIT && out_free) begin
      res <= pend;
    end
  end

endmodule

[verif/grid_hole_neighbour_fill_core_tb.sv]
// ----------------------------------------------------------------------------
// grid_hole_neighbour_fill_core_tb
// Self-checking bench for the height grid with neighbour fill on read. A
// shadow grid predicts every read result. Directed corner and side-limit
// cases run first. A long output stall follows, then randomized write/read
// traffic over several grid sides and idle patterns.
// ----------------------------------------------------------------------------
module grid_hole_neighbour_fill_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ghnf_pkg::*;

  localparam int CLK_HALF         = 10;
  localparam int RESET_CYCLES     = 12;
  localparam int SETTLE_CYCLES    = 16;
  localparam int DRAIN_LIMIT      = 50000;
  localparam int RANDOM_PER_PHASE = 100;
  localparam int HOLD_CYCLES      = 400;
  localparam int TIMEOUT_NS       = 10_000_000;
  localparam int NUM_PHASES       = 12;

  localparam logic [MARK_W-1:0] MARK_CODE3 = 2'd3;

  // neighbour probe order: left column, right column, then below and above
  localparam int PROBE_DR [NUM_PROBES] = '{0, -1, 1, 0, -1, 1, -1, 1};
  localparam int PROBE_DC [NUM_PROBES] = '{-1, -1, -1, 1, 1, 1, 0, 0};

  // grid sides per random phase, out-of-range codes included
  localparam int PHASE_SIDES [NUM_PHASES] = '{2, 5, 63, 3, 0, 8, 33, 4, 1, 6, 32, 7};

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_stall;
  item_t               item       = '0;
  logic                res_valid;
  logic                res_stall  = 1'b0;
  result_t             res;
  logic                cfg_we     = 1'b0;
  logic [SIDE_W-1:0]   cfg_data   = '0;

  // shadow grid and side register
  logic signed [HEIGHT_BITS-1:0] grid_height [CELLS];
  logic [MARK_W-1:0]             grid_mark [CELLS];
  bit                            grid_written [CELLS];
  logic [SIDE_W-1:0]             side_reg = 6'd32;

  result_t reads_due [$];
  int      errors    = 0;
  int      send_pct  = 0;
  int      stall_pct = 0;
  int      hold_left = 0;

  grid_hole_neighbour_fill_core u_top (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data)
  );

  initial forever #(CLK_HALF) clk = ~clk;

  // run time limit
  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

  function automatic void note_error(string msg);
    if (errors < 10) $display("%s", msg);
    errors++;
  endfunction

  function automatic int active_side();
    if (side_reg < 2) return 2;
    if (side_reg > MAX_SIDE) return MAX_SIDE;
    return int'(side_reg);
  endfunction

  function automatic bit on_grid(int r, int c, int s);
    return r >= 0 && c >= 0 && r < s && c < s;
  endfunction

  // a read may touch the vertex and any in-grid neighbour; all must be loaded
  function automatic bit read_is_safe(int r, int c);
    int s;
    int idx;
    s = active_side();
    if (!on_grid(r, c, s)) return 1'b1;
    idx = r * s + c;
    if (!grid_written[idx]) return 1'b0;
    if (grid_mark[idx] != MARK_UNDEF) return 1'b1;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if ((dr != 0 || dc != 0) && on_grid(r + dr, c + dc, s) &&
            !grid_written[(r + dr) * s + c + dc]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // update the shadow grid and queue the result a read will produce
  function automatic void apply_grid_item(item_t it);
    int      s;
    int      r;
    int      c;
    int      idx;
    int      nr;
    int      nc;
    result_t fill;
    s = active_side();
    r = int'(it.row);
    c = int'(it.col);
    if (!on_grid(r, c, s)) return;
    idx = r * s + c;
    if (it.func == FUNC_WRITE) begin
      grid_height[idx]  = it.height;
      grid_mark[idx]    = (it.mark == MARK_CODE3) ? MARK_OTHER : it.mark;
      grid_written[idx] = 1'b1;
      return;
    end
    fill.height_res     = grid_height[idx];
    fill.mark_res       = grid_mark[idx];
    fill.from_neighbour = 1'b0;
    if (grid_mark[idx] == MARK_UNDEF) begin
      for (int k = 0; k < NUM_PROBES && !fill.from_neighbour; k++) begin
        nr = r + PROBE_DR[k];
        nc = c + PROBE_DC[k];
        if (on_grid(nr, nc, s) && grid_mark[nr * s + nc] == MARK_MOSAIC) begin
          fill.height_res     = grid_height[nr * s + nc];
          fill.from_neighbour = 1'b1;
        end
      end
    end
    reads_due = {reads_due, fill};
  endfunction

  // result checker
  always @(posedge clk) begin : check_result
    result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (reads_due.size() == 0) begin
        note_error($sformatf("unexpected result: h=%0d m=%0d n=%0b",
                             res.height_res, res.mark_res, res.from_neighbour));
      end else begin
        want = reads_due.pop_front();
        if (res.height_res !== want.height_res || res.mark_res !== want.mark_res ||
            res.from_neighbour !== want.from_neighbour) begin
          note_error($sformatf(
            "result mismatch: expected h=%0d m=%0d n=%0b, got h=%0d m=%0d n=%0b",
            want.height_res, want.mark_res, want.from_neighbour,
            res.height_res, res.mark_res, res.from_neighbour));
        end
      end
    end
  end

  // output stall: long hold-off when requested, random otherwise
  always @(negedge clk) begin
    if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left--;
    end else begin
      res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic item_t make_write(int r, int c, logic [HEIGHT_BITS-1:0] h,
                                       logic [MARK_W-1:0] m);
    item_t it;
    it.func   = FUNC_WRITE;
    it.row    = r[COORD_W-1:0];
    it.col    = c[COORD_W-1:0];
    it.height = h;
    it.mark   = m;
    return it;
  endfunction

  // height and mark of a read carry noise
  function automatic item_t make_read(int r, int c);
    item_t it;
    it.func   = FUNC_READ;
    it.row    = r[COORD_W-1:0];
    it.col    = c[COORD_W-1:0];
    it.height = HEIGHT_BITS'($urandom);
    it.mark   = MARK_W'($urandom);
    return it;
  endfunction

  function automatic logic [MARK_W-1:0] pick_mark();
    int pick;
    pick = $urandom_range(19);
    if (pick < 7) return MARK_UNDEF;
    if (pick < 14) return MARK_MOSAIC;
    if (pick < 18) return MARK_OTHER;
    return MARK_CODE3;
  endfunction

  function automatic logic [HEIGHT_BITS-1:0] pick_height();
    case ($urandom_range(7))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return 24'h000000;
      3:       return 24'hFFFFFF;
      default: return HEIGHT_BITS'($urandom);
    endcase
  endfunction

  function automatic int window_start(int s, int len);
    case ($urandom_range(2))
      0:       return 0;
      1:       return s - len;
      default: return $urandom_range(s - len);
    endcase
  endfunction

  task automatic set_traffic(int sp, int rp);
    send_pct  = sp;
    stall_pct = rp;
  endtask

  // one input transaction, with random idle cycles ahead of it
  task automatic drive_item(item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    apply_grid_item(it);
  endtask

  // drop valid and wait until every read result is back
  task automatic wait_idle();
    @(negedge clk);
    item_valid <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && reads_due.size() != 0; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_grid_side(logic [SIDE_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    side_reg = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic fill_area(int r_lo, int r_hi, int c_lo, int c_hi);
    for (int r = r_lo; r <= r_hi; r++) begin
      for (int c = c_lo; c <= c_hi; c++) begin
        drive_item(make_write(r, c, pick_height(), pick_mark()));
      end
    end
  endtask

  // corners of the reset-size grid: right fill, lower-left fill, no fill, then two defined reads
  task automatic test_reset_corners();
    set_traffic(0, 0);
    drive_item(make_write(0, 0, 24'h000100, MARK_UNDEF));
    drive_item(make_write(0, 1, 24'h7FFFFF, MARK_MOSAIC));
    drive_item(make_write(1, 0, 24'h000200, MARK_OTHER));
    drive_item(make_write(1, 1, 24'h000300, MARK_OTHER));
    drive_item(make_read(0, 0));
    drive_item(make_write(31, 31, 24'h0000AA, MARK_UNDEF));
    drive_item(make_write(31, 30, 24'h111111, MARK_OTHER));
    drive_item(make_write(30, 30, 24'h800000, MARK_MOSAIC));
    drive_item(make_write(30, 31, 24'h123456, MARK_MOSAIC));
    drive_item(make_read(31, 31));
    drive_item(make_write(31, 0, 24'h5A5A5A, MARK_UNDEF));
    drive_item(make_write(30, 0, 24'hA5A5A5, MARK_OTHER));
    drive_item(make_write(30, 1, 24'hFFFFFF, MARK_UNDEF));
    drive_item(make_write(31, 1, 24'h0F0F0F, MARK_CODE3));
    drive_item(make_read(31, 0));
    drive_item(make_read(31, 1));
    drive_item(make_read(30, 0));
  endtask

  // side below minimum, positions past the edge dropped without aliasing
  task automatic test_side_limits();
    set_traffic(0, 0);
    load_grid_side(6'd1);
    drive_item(make_write(0, 0, 24'h000042, MARK_UNDEF));
    drive_item(make_write(0, 1, 24'h000043, MARK_OTHER));
    drive_item(make_write(1, 0, 24'h000044, MARK_OTHER));
    drive_item(make_write(1, 1, 24'h3C3C3C, MARK_MOSAIC));
    drive_item(make_write(0, 2, 24'h777777, MARK_MOSAIC));
    drive_item(make_write(3, 3, 24'h666666, MARK_MOSAIC));
    drive_item(make_read(0, 0));
    drive_item(make_read(1, 0));
    drive_item(make_read(2, 1));
  endtask

  // long output hold-off fills the block and backs up the input
  task automatic test_output_hold();
    set_traffic(0, 0);
    load_grid_side(6'd3);
    fill_area(0, 2, 0, 2);
    wait_idle();
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    repeat (30) drive_item(make_read($urandom_range(2), $urandom_range(2)));
    wait_idle();
  endtask

  // random write/read traffic, mostly inside a window of each grid side
  task automatic test_random_traffic();
    int s;
    int r0;
    int c0;
    int h;
    int w;
    int r;
    int c;
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0:       set_traffic(0, 0);
        1:       set_traffic(76, 0);
        2:       set_traffic(0, 76);
        default: set_traffic(38, 38);
      endcase
      load_grid_side(SIDE_W'(PHASE_SIDES[p]));
      s = active_side();
      if (s <= 6) begin
        r0 = 0;
        c0 = 0;
        h  = s;
        w  = s;
      end else begin
        h  = $urandom_range(3, 6);
        w  = $urandom_range(3, 6);
        r0 = window_start(s, h);
        c0 = window_start(s, w);
      end
      // load the window and its border so reads inside stay legal
      fill_area((r0 > 0) ? r0 - 1 : 0, (r0 + h < s) ? r0 + h : s - 1,
                (c0 > 0) ? c0 - 1 : 0, (c0 + w < s) ? c0 + w : s - 1);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (s < MAX_SIDE && $urandom_range(9) == 0) begin
          r = $urandom_range(31);
          c = $urandom_range(31);
        end else begin
          r = r0 + $urandom_range(h - 1);
          c = c0 + $urandom_range(w - 1);
        end
        if ($urandom_range(99) < 55 && read_is_safe(r, c)) begin
          drive_item(make_read(r, c));
        end else begin
          drive_item(make_write(r, c, pick_height(), pick_mark()));
        end
      end
    end
  endtask

  // test sequence
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_corners();
    test_side_limits();
    test_output_hold();
    test_random_traffic();
    wait_idle();
    if (reads_due.size() != 0) begin
      note_error($sformatf("%0d read results never arrived", reads_due.size()));
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
hdl/ghnf_pkg.sv
hdl/ghnf_store.sv
hdl/grid_hole_neighbour_fill_core.sv
verif/grid_hole_neighbour_fill_core_tb.sv
